// File: sv/spq_pkg.sv
// package for the stable sorted priority queue
// constants, state and status codes used by the modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int HANDLE_BITS   = 16;
  localparam int SOURCE_BITS   = 8;
  localparam int PRIORITY_BITS = 4;
  localparam int NUM_PRIO      = 1 << PRIORITY_BITS;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W     = ((HANDLE_BITS + SOURCE_BITS + PRIORITY_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = HANDLE_BITS + SOURCE_BITS + PRIORITY_BITS + CNT_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH_FIX,
    S_POP_RD
  } state_t;

  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;

endpackage
`default_nettype wire

// File: sv/spq_lowest.sv
// finds the lowest priority class that holds at least one entry
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none
module spq_lowest
  import spq_pkg::*;
(
  input  wire logic [NUM_PRIO-1:0] nonempty,
  output prio_t                    lowest
);

  // scan from the top so the lowest set bit wins
  always_comb begin
    lowest = '0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        lowest = prio_t'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/stable_sorted_priority_queue.sv
// top level of the stable sorted priority queue
// depends on spq_pkg and spq_lowest
//
// usage:
//   in_ beats carry one request. in_tuser is the command (push or pop),
//   in_tdata the entry fields. every request gives exactly one out_ beat with
//   a status (ok, full, empty), the removed head on a good pop, and the
//   occupancy after the request.
//   entries live in a shared slot memory; each priority class is a linked
//   list (head/tail per class) threaded through a next-pointer memory, so
//   the lowest nonempty class gives the head and arrival order is kept.
//   freed slots go on a free list in the same next-pointer memory; slots
//   never used yet are handed out by a counter, so no clearing pass is run.
//   a push result is registered and shows the cycle after acceptance; a pop
//   result first passes through the registered memory read in S_POP_RD.
//   a pop spends the S_POP_RD state on the memory read, while a push that
//   reuses a freed slot updates the free list in S_PUSH_FIX while its result
//   is offered.
//   a new request is taken only once the previous result has been taken.
//   reset empties the queue and holds in_tready low; a stalled receiver holds
//   the result and the input side waits.
`timescale 1ns / 1ps
`default_nettype none
module stable_sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: packet_handle, source_id, priority_req, zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata: popped_handle, popped_source, popped_priority, occupancy, zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // tuser: status
  output logic [1:0]                 out_tuser
);

  localparam int ENTRY_W = HANDLE_BITS + SOURCE_BITS;

  // input fields
  logic [HANDLE_BITS-1:0] in_handle;
  logic [SOURCE_BITS-1:0] in_source;
  prio_t                  in_prio;
  assign in_handle = in_tdata[HANDLE_BITS-1:0];
  assign in_source = in_tdata[HANDLE_BITS +: SOURCE_BITS];
  assign in_prio   = in_tdata[HANDLE_BITS + SOURCE_BITS +: PRIORITY_BITS];

  // memories
  logic [ENTRY_W-1:0] data_mem [QUEUE_DEPTH];
  ptr_t               next_mem [QUEUE_DEPTH];

  // control state
  state_t                state_r, state_nxt;
  logic [NUM_PRIO-1:0]   nonempty_r, nonempty_nxt;
  ptr_t                  head_r [NUM_PRIO];
  ptr_t                  tail_r [NUM_PRIO];
  ptr_t                  free_head_r, free_head_nxt;
  logic [CNT_W-1:0]      fresh_r, fresh_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  prio_t                 pop_prio_r, pop_prio_nxt;
  ptr_t                  pop_slot_r, pop_slot_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r, out_handle_nxt;
  logic [SOURCE_BITS-1:0] out_source_r, out_source_nxt;
  prio_t                  out_prio_r, out_prio_nxt;
  logic [CNT_W-1:0]       out_occ_r, out_occ_nxt;

  // memory ports
  logic               data_we;
  ptr_t               data_waddr, data_raddr;
  logic [ENTRY_W-1:0] data_wdata, data_rd_r;
  logic               next_we;
  ptr_t               next_waddr, next_raddr, next_wdata, next_rd_r;

  // class table updates
  logic  head_we, tail_we;
  prio_t head_widx, tail_widx;
  ptr_t  head_wdata, tail_wdata;

  prio_t lowest;
  prio_t sel_prio;
  ptr_t  sel_head, sel_tail;
  logic  accept;

  spq_lowest u_lowest (
    .nonempty (nonempty_r),
    .lowest   (lowest)
  );

  assign accept   = in_tvalid && in_tready;
  assign sel_prio = (state_r == S_POP_RD) ? pop_prio_r
                  : ((in_tuser == CMD_POP) ? lowest : in_prio);
  assign sel_head = head_r[sel_prio];
  assign sel_tail = tail_r[sel_prio];

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rd_r <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_r <= next_mem[next_raddr];
  end

  // per-class head and tail pointers
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[head_widx] <= head_wdata;
    end
    if (tail_we) begin
      tail_r[tail_widx] <= tail_wdata;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      free_head_r <= '0;
      fresh_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pop_prio_r   <= pop_prio_nxt;
    pop_slot_r   <= pop_slot_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_source_r <= out_source_nxt;
    out_prio_r   <= out_prio_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    nonempty_nxt   = nonempty_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    occ_nxt        = occ_r;
    pop_prio_nxt   = pop_prio_r;
    pop_slot_nxt   = pop_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_source_nxt = out_source_r;
    out_prio_nxt   = out_prio_r;
    out_occ_nxt    = out_occ_r;
    in_tready      = 1'b0;
    data_we        = 1'b0;
    data_waddr     = '0;
    data_wdata     = {in_source, in_handle};
    data_raddr     = sel_head;
    next_we        = 1'b0;
    next_waddr     = sel_tail;
    next_wdata     = '0;
    next_raddr     = free_head_r;
    head_we        = 1'b0;
    head_widx      = sel_prio;
    head_wdata     = '0;
    tail_we        = 1'b0;
    tail_widx      = sel_prio;
    tail_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n && !out_valid_r;
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          out_source_nxt = '0;
          out_prio_nxt   = '0;
          if (in_tuser == CMD_PUSH) begin
            if (occ_r == CNT_W'(QUEUE_DEPTH)) begin
              out_status_nxt = ST_FULL;
              out_occ_nxt    = occ_r;
            end else begin
              // take a never-used slot first, else the free list head
              if (fresh_r != CNT_W'(QUEUE_DEPTH)) begin
                data_waddr = fresh_r[PTR_W-1:0];
                fresh_nxt  = fresh_r + CNT_W'(1);
              end else begin
                data_waddr = free_head_r;
                next_raddr = free_head_r;
                state_nxt  = S_PUSH_FIX;
              end
              data_we = 1'b1;
              // append to the tail of its class
              if (nonempty_r[in_prio]) begin
                next_we    = 1'b1;
                next_waddr = sel_tail;
                next_wdata = data_waddr;
              end else begin
                head_we    = 1'b1;
                head_wdata = data_waddr;
              end
              tail_we                = 1'b1;
              tail_wdata             = data_waddr;
              nonempty_nxt[in_prio]  = 1'b1;
              occ_nxt                = occ_r + CNT_W'(1);
              out_status_nxt         = ST_OK;
              out_occ_nxt            = occ_r + CNT_W'(1);
            end
          end else begin
            if (occ_r == '0) begin
              out_status_nxt = ST_EMPTY;
              out_occ_nxt    = occ_r;
            end else begin
              // read head entry and its successor, finish next cycle
              out_valid_nxt = 1'b0;
              data_raddr    = sel_head;
              next_raddr    = sel_head;
              pop_prio_nxt  = lowest;
              pop_slot_nxt  = sel_head;
              state_nxt     = S_POP_RD;
            end
          end
        end
      end
      S_PUSH_FIX: begin
        free_head_nxt = next_rd_r;
        state_nxt     = S_IDLE;
      end
      S_POP_RD: begin
        if (sel_head == sel_tail) begin
          nonempty_nxt[pop_prio_r] = 1'b0;
        end else begin
          head_we    = 1'b1;
          head_wdata = next_rd_r;
        end
        // slot goes back on the free list
        next_we        = 1'b1;
        next_waddr     = pop_slot_r;
        next_wdata     = free_head_r;
        free_head_nxt  = pop_slot_r;
        occ_nxt        = occ_r - CNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_handle_nxt = data_rd_r[HANDLE_BITS-1:0];
        out_source_nxt = data_rd_r[HANDLE_BITS +: SOURCE_BITS];
        out_prio_nxt   = pop_prio_r;
        out_occ_nxt    = occ_r - CNT_W'(1);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'({out_occ_r, out_prio_r, out_source_r, out_handle_r});

endmodule
`default_nettype wire

// File: test/stable_sorted_priority_queue_test.sv
// testbench for the stable sorted priority queue
// drives push/pop beats with random gaps and stalls, checks against a local queue model
// depends on spq_pkg and stable_sorted_priority_queue
`timescale 1ns / 1ps
module stable_sorted_priority_queue_test;
  import spq_pkg::*;

  typedef struct packed {
    logic             cmd;
    logic [HANDLE_BITS-1:0]   handle;
    logic [SOURCE_BITS-1:0]   source;
    logic [PRIORITY_BITS-1:0] prio;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic [HANDLE_BITS-1:0]   handle;
    logic [SOURCE_BITS-1:0]   source;
    logic [PRIORITY_BITS-1:0] prio;
    logic [CNT_W-1:0]         occupancy;
  } response_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0]   handle;
    logic [SOURCE_BITS-1:0]   source;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  entry_t    sorted_entries[$];
  int        mismatch_count;
  int        cycle_count;
  int        send_gap;
  int        recv_gap;
  int        hold_off;
  bit        stim_done;
  bit        sampled_in_accept;

  stable_sorted_priority_queue u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // queue model: stable insert by priority, pop from head
  function automatic response_t queue_apply(request_t req);
    response_t r;
    entry_t    e;
    int        pos;
    r = '0;
    r.status = ST_OK;
    if (req.cmd == CMD_PUSH) begin
      if (sorted_entries.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.handle = req.handle;
        e.source = req.source;
        e.prio = req.prio;
        pos = sorted_entries.size();
        while (pos > 0 && sorted_entries[pos-1].prio > req.prio) pos--;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = sorted_entries.pop_front();
      r.handle = e.handle;
      r.source = e.source;
      r.prio = e.prio;
    end
    r.occupancy = CNT_W'(sorted_entries.size());
    return r;
  endfunction

  function automatic request_t make_req(logic cmd, int prio);
    request_t q;
    q.cmd = cmd;
    q.handle = HANDLE_BITS'($urandom);
    q.source = SOURCE_BITS'($urandom);
    q.prio = PRIORITY_BITS'(prio);
    return q;
  endfunction

  // stimulus
  initial begin
    int n;
    int push_pct;
    stim_done = 1'b0;
    // directed: empty pop, extremes, equal priorities, drain
    pending_reqs.push_back(make_req(CMD_POP, 0));
    pending_reqs.push_back('{CMD_PUSH, 16'hffff, 8'hff, 4'hf});
    pending_reqs.push_back('{CMD_PUSH, 16'h0000, 8'h00, 4'h0});
    pending_reqs.push_back('{CMD_PUSH, 16'h1234, 8'h5a, 4'h7});
    pending_reqs.push_back('{CMD_PUSH, 16'h4321, 8'ha5, 4'h7});
    pending_reqs.push_back('{CMD_PUSH, 16'h0001, 8'h01, 4'h0});
    for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(CMD_POP, 0));
    // long random phases swinging between filling and draining
    while (pending_reqs.size() < 1340) begin
      push_pct = ($urandom_range(0, 1) != 0) ? 85 : 25;
      n = $urandom_range(20, 140);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          pending_reqs.push_back(make_req(CMD_PUSH, $urandom_range(0, 15)));
        else
          pending_reqs.push_back(make_req(CMD_POP, 0));
      end
    end
    // make sure the queue runs full and then empty at the end
    for (int i = 0; i < 70; i++) pending_reqs.push_back(make_req(CMD_PUSH, $urandom_range(0, 3)));
    for (int i = 0; i < 70; i++) pending_reqs.push_back(make_req(CMD_POP, 0));
    stim_done = 1'b1;
  end

  // reset and input defaults
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // driver: one beat at a time with a random gap
  always @(negedge clk) begin
    if (!rst_n) begin
      send_gap <= 0;
    end else if (in_tvalid && !sampled_in_accept) begin
      // beat still waiting for acceptance
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (stim_done && pending_reqs.size() > 0) begin
      request_t q;
      q = pending_reqs.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= q.cmd;
      in_tdata <= IN_DATA_W'({q.prio, q.source, q.handle});
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    sampled_in_accept <= 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      request_t q;
      q.cmd = in_tuser;
      {q.prio, q.source, q.handle} = in_tdata[HANDLE_BITS+SOURCE_BITS+PRIORITY_BITS-1:0];
      expected_resps.push_back(queue_apply(q));
      sampled_in_accept <= 1'b1;
    end
  end

  // receiver ready: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      recv_gap <= 0;
      hold_off <= 0;
    end else if (cycle_count == 3000) begin
      out_tready <= 1'b0;
      hold_off <= 400;
    end else if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready)
        recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      response_t got;
      response_t want;
      got.status = status_t'(out_tuser);
      {got.occupancy, got.prio, got.source, got.handle} = out_tdata[OUT_FIELDS_W-1:0];
      if (expected_resps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_resps.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // end of run
  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    wait (stim_done);
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_tvalid || expected_resps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_resps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_lowest.sv
sv/stable_sorted_priority_queue.sv
test/stable_sorted_priority_queue_test.sv
